### rtl/pws_pkg.sv
// ----------------------------------------------------------------------------
// pws_pkg
// Shared types, constants and fixed-point helpers for the polynomial
// waveshaper.
// ----------------------------------------------------------------------------
package pws_pkg;

    localparam int ACC_W  = 32;
    localparam int U_W    = 23;
    localparam int COEF_W = 16;
    localparam int REG_W  = 16;

    localparam logic signed [63:0] Q_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] Q_MIN = -64'sh0000_0000_8000_0000;

    localparam logic [REG_W-1:0] DRIVE_RST = 16'd2048;
    localparam logic [REG_W-1:0] WET_RST   = 16'd32768;
    localparam logic [REG_W-1:0] GAIN_RST  = 16'd4096;
    localparam logic [REG_W:0]   WET_FULL  = 17'd32768;

    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic signed [U_W-1:0]    t_u;
    typedef logic signed [COEF_W-1:0] t_coef;

    typedef struct packed {
        logic valid;
        logic eob;
    } t_pipe_ctl;

    typedef struct packed {
        logic [63:0]      coef_lo;
        logic [63:0]      coef_hi;
        logic [REG_W-1:0] coef_top;
        logic [REG_W-1:0] drive;
        logic [REG_W-1:0] wet;
        logic [REG_W-1:0] gain;
    } t_cfg;

    typedef enum logic [2:0] {
        REG_COEF_LO  = 3'd0,
        REG_COEF_HI  = 3'd1,
        REG_COEF_TOP = 3'd2,
        REG_DRIVE    = 3'd3,
        REG_WET      = 3'd4,
        REG_GAIN     = 3'd5
    } t_reg_idx;

    function automatic t_acc f_sat32(input logic signed [63:0] v);
        t_acc r;
        if (v > Q_MAX) begin
            r = t_acc'(Q_MAX);
        end else if (v < Q_MIN) begin
            r = t_acc'(Q_MIN);
        end else begin
            r = t_acc'(v);
        end
        return r;
    endfunction

    function automatic t_coef f_coef_raw(input t_cfg cfg, input logic [3:0] k);
        t_coef r;
        if (k[3]) begin
            r = cfg.coef_top;
        end else if (k[2]) begin
            r = cfg.coef_hi[16*k[1:0] +: 16];
        end else begin
            r = cfg.coef_lo[16*k[1:0] +: 16];
        end
        return r;
    endfunction

    function automatic t_acc f_coef_q16(input t_coef c);
        return {{(ACC_W-COEF_W-4){c[COEF_W-1]}}, c, 4'b0000};
    endfunction

endpackage

### rtl/pws_in_if.sv
// ----------------------------------------------------------------------------
// pws_in_if
// Input item channel: one sample and its end-of-buffer mark.
// ----------------------------------------------------------------------------
interface pws_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          end_of_buffer;

    modport source (output valid, output sample_in, output end_of_buffer, input ready);
    modport sink   (input valid, input sample_in, input end_of_buffer, output ready);
endinterface

### rtl/pws_out_if.sv
// ----------------------------------------------------------------------------
// pws_out_if
// Result item channel: one shaped sample and its end-of-buffer mark.
// ----------------------------------------------------------------------------
interface pws_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          end_of_buffer_out;

    modport source (output valid, output sample_out, output end_of_buffer_out, input ready);
    modport sink   (input valid, input sample_out, input end_of_buffer_out, output ready);
endinterface

### rtl/polynomial_waveshaper.sv
// ----------------------------------------------------------------------------
// polynomial_waveshaper
// Pipeline: the drive stage, then one multiply and one add stage per Horner
// step, then the mix stages.
// Throughput: one item per cycle; stages hold in place under output stall.
// Reset: synchronous, active low; clears the pipeline and loads the register
// defaults (drive 1.0, fully wet, unity gain, zero coefficients).
// ----------------------------------------------------------------------------
module polynomial_waveshaper #(
    parameter int POLY_ORDER  = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    pws_in_if.sink      i_item,
    pws_out_if.source   o_item
);
    import pws_pkg::*;

    t_cfg                          cfg;
    t_pipe_ctl                     in_ctl, out_ctl;
    t_pipe_ctl                     ctl_c  [POLY_ORDER+1];
    logic signed [SAMPLE_BITS-1:0] x_c    [POLY_ORDER+1];
    t_u                            u_c    [POLY_ORDER+1];
    t_acc                          acc_c  [POLY_ORDER+1];
    logic                          take_c [POLY_ORDER+1];
    logic                          take_in;
    logic signed [SAMPLE_BITS-1:0] sample;

    pws_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign in_ctl.valid = i_item.valid;
    assign in_ctl.eob   = i_item.end_of_buffer;
    assign i_item.ready = take_in;

    pws_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .POLY_ORDER  (POLY_ORDER)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_ctl   (in_ctl),
        .i_x     (i_item.sample_in),
        .i_take  (take_c[0]),
        .o_take  (take_in),
        .o_ctl   (ctl_c[0]),
        .o_x     (x_c[0]),
        .o_u     (u_c[0]),
        .o_acc   (acc_c[0])
    );

    for (genvar j = 0; j < POLY_ORDER; j++) begin : g_step
        pws_horner_step #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_coef  (f_coef_raw(cfg, 4'(POLY_ORDER - 1 - j))),
            .i_ctl   (ctl_c[j]),
            .i_x     (x_c[j]),
            .i_u     (u_c[j]),
            .i_acc   (acc_c[j]),
            .i_take  (take_c[j+1]),
            .o_take  (take_c[j]),
            .o_ctl   (ctl_c[j+1]),
            .o_x     (x_c[j+1]),
            .o_u     (u_c[j+1]),
            .o_acc   (acc_c[j+1])
        );
    end

    pws_mix #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_ctl    (ctl_c[POLY_ORDER]),
        .i_x      (x_c[POLY_ORDER]),
        .i_acc    (acc_c[POLY_ORDER]),
        .i_take   (o_item.ready),
        .o_take   (take_c[POLY_ORDER]),
        .o_ctl    (out_ctl),
        .o_sample (sample)
    );

    assign o_item.valid             = out_ctl.valid;
    assign o_item.end_of_buffer_out = out_ctl.eob;
    assign o_item.sample_out        = sample;

endmodule

### rtl/pws_cfg.sv
// ----------------------------------------------------------------------------
// pws_cfg
// APB register file: coefficients, drive, wet share and output gain.
// ----------------------------------------------------------------------------
module pws_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [5:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready,
    output pws_pkg::t_cfg o_cfg
);
    import pws_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr;

    assign idx    = t_reg_idx'(paddr[5:3]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef_lo  <= '0;
            r_cfg.coef_hi  <= '0;
            r_cfg.coef_top <= '0;
            r_cfg.drive    <= DRIVE_RST;
            r_cfg.wet      <= WET_RST;
            r_cfg.gain     <= GAIN_RST;
        end else if (wr) begin
            case (idx)
                REG_COEF_LO:  r_cfg.coef_lo  <= pwdata;
                REG_COEF_HI:  r_cfg.coef_hi  <= pwdata;
                REG_COEF_TOP: r_cfg.coef_top <= pwdata[REG_W-1:0];
                REG_DRIVE:    r_cfg.drive    <= pwdata[REG_W-1:0];
                REG_WET:      r_cfg.wet      <= pwdata[REG_W-1:0];
                REG_GAIN:     r_cfg.gain     <= pwdata[REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_COEF_LO:  prdata = r_cfg.coef_lo;
            REG_COEF_HI:  prdata = r_cfg.coef_hi;
            REG_COEF_TOP: prdata = 64'(r_cfg.coef_top);
            REG_DRIVE:    prdata = 64'(r_cfg.drive);
            REG_WET:      prdata = 64'(r_cfg.wet);
            REG_GAIN:     prdata = 64'(r_cfg.gain);
            default:      prdata = '0;
        endcase
    end

endmodule

### rtl/pws_front.sv
// ----------------------------------------------------------------------------
// pws_front
// Drive scaling stage: forms u = x*drive in Q7.16 and seeds the accumulator
// with the top coefficient.
// ----------------------------------------------------------------------------
module pws_front #(
    parameter int SAMPLE_BITS = 16,
    parameter int POLY_ORDER  = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pws_pkg::t_cfg                 i_cfg,
    input  pws_pkg::t_pipe_ctl            i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic                          i_take,
    output logic                          o_take,
    output pws_pkg::t_pipe_ctl            o_ctl,
    output logic signed [SAMPLE_BITS-1:0] o_x,
    output pws_pkg::t_u                   o_u,
    output pws_pkg::t_acc                 o_acc
);
    import pws_pkg::*;

    t_pipe_ctl                     r_ctl;
    logic signed [SAMPLE_BITS-1:0] r_x;
    t_u                            r_u;
    t_acc                          r_acc;
    logic                          en;
    logic signed [SAMPLE_BITS+16:0] prod;

    assign en     = !r_ctl.valid || i_take;
    assign o_take = en;
    assign prod   = i_x * $signed({1'b0, i_cfg.drive});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x   <= i_x;
            r_u   <= U_W'(prod >>> (SAMPLE_BITS - 6));
            r_acc <= f_coef_q16(f_coef_raw(i_cfg, 4'(POLY_ORDER)));
        end
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_u   = r_u;
    assign o_acc = r_acc;

endmodule

### rtl/pws_horner_step.sv
// ----------------------------------------------------------------------------
// pws_horner_step
// One Horner iteration in two stages: multiply acc*u, then floor, saturate,
// add the coefficient and saturate again.
// ----------------------------------------------------------------------------
module pws_horner_step #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pws_pkg::t_coef                i_coef,
    input  pws_pkg::t_pipe_ctl            i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  pws_pkg::t_u                   i_u,
    input  pws_pkg::t_acc                 i_acc,
    input  logic                          i_take,
    output logic                          o_take,
    output pws_pkg::t_pipe_ctl            o_ctl,
    output logic signed [SAMPLE_BITS-1:0] o_x,
    output pws_pkg::t_u                   o_u,
    output pws_pkg::t_acc                 o_acc
);
    import pws_pkg::*;

    localparam int PROD_W = ACC_W + U_W;

    t_pipe_ctl                     r_a_ctl, r_b_ctl;
    logic signed [SAMPLE_BITS-1:0] r_a_x, r_b_x;
    t_u                            r_a_u, r_b_u;
    logic signed [PROD_W-1:0]      r_a_prod;
    t_acc                          r_b_acc;
    logic signed [PROD_W-1:0]      n_prod;
    t_acc                          scaled;
    t_acc                          n_acc;
    logic                          en_a, en_b;

    assign en_b   = !r_b_ctl.valid || i_take;
    assign en_a   = !r_a_ctl.valid || en_b;
    assign o_take = en_a;

    assign n_prod = i_acc * i_u;
    assign scaled = f_sat32(64'(r_a_prod >>> 16));
    assign n_acc  = f_sat32(64'(scaled) + 64'(f_coef_q16(i_coef)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
            r_b_ctl <= '0;
        end else begin
            if (en_a) begin
                r_a_ctl <= i_ctl;
            end
            if (en_b) begin
                r_b_ctl <= r_a_ctl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_x    <= i_x;
            r_a_u    <= i_u;
            r_a_prod <= n_prod;
        end
        if (en_b) begin
            r_b_x   <= r_a_x;
            r_b_u   <= r_a_u;
            r_b_acc <= n_acc;
        end
    end

    assign o_ctl = r_b_ctl;
    assign o_x   = r_b_x;
    assign o_u   = r_b_u;
    assign o_acc = r_b_acc;

endmodule

### rtl/pws_mix.sv
// ----------------------------------------------------------------------------
// pws_mix
// Wet/dry mix, output gain and clip in four stages; the last stage is the
// output register.
// ----------------------------------------------------------------------------
module pws_mix #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pws_pkg::t_cfg                 i_cfg,
    input  pws_pkg::t_pipe_ctl            i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  pws_pkg::t_acc                 i_acc,
    input  logic                          i_take,
    output logic                          o_take,
    output pws_pkg::t_pipe_ctl            o_ctl,
    output logic signed [SAMPLE_BITS-1:0] o_sample
);
    import pws_pkg::*;

    localparam int WP_W = ACC_W + REG_W + 2;
    localparam int DP_W = SAMPLE_BITS + REG_W + 2;
    localparam int YP_W = ACC_W + REG_W + 1;
    localparam int LSH  = (SAMPLE_BITS > 17) ? SAMPLE_BITS - 17 : 0;
    localparam int RSH  = (SAMPLE_BITS > 17) ? 0 : 17 - SAMPLE_BITS;
    localparam int YW   = ACC_W + LSH;
    localparam logic signed [YW-1:0] CLIP =
        YW'((64'd99 * (64'd1 << (SAMPLE_BITS - 1))) / 64'd100);

    t_pipe_ctl                     r_ctl [4];
    logic                          en    [4];

    logic signed [WP_W-1:0]        r1_wprod;
    logic signed [DP_W-1:0]        r1_dprod;
    t_acc                          r2_mix;
    logic signed [YP_W-1:0]        r3_yprod;
    logic signed [SAMPLE_BITS-1:0] r4_sample;

    logic [REG_W:0]                m, dry_w;
    t_acc                          wet, n_mix, y;
    logic signed [YW-1:0]          y_sc, y_clip;

    assign en[3]  = !r_ctl[3].valid || i_take;
    assign en[2]  = !r_ctl[2].valid || en[3];
    assign en[1]  = !r_ctl[1].valid || en[2];
    assign en[0]  = !r_ctl[0].valid || en[1];
    assign o_take = en[0];

    assign m     = (i_cfg.wet > WET_FULL[REG_W-1:0] && !WET_FULL[REG_W]) ||
                   ({1'b0, i_cfg.wet} > WET_FULL) ? WET_FULL : {1'b0, i_cfg.wet};
    assign dry_w = WET_FULL - m;

    assign wet   = f_sat32(64'(r1_wprod >>> 15));
    assign n_mix = f_sat32(64'(wet) + 64'(r1_dprod >>> (SAMPLE_BITS - 2)));

    assign y      = f_sat32(64'(r3_yprod >>> 12));
    assign y_sc   = (YW'(y) <<< LSH) >>> RSH;
    assign y_clip = (y_sc > CLIP) ? CLIP : ((y_sc < -CLIP) ? -CLIP : y_sc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_ctl[i] <= '0;
            end
        end else begin
            if (en[0]) begin
                r_ctl[0] <= i_ctl;
            end
            for (int i = 1; i < 4; i++) begin
                if (en[i]) begin
                    r_ctl[i] <= r_ctl[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_wprod <= i_acc * $signed({1'b0, m});
            r1_dprod <= i_x * $signed({1'b0, dry_w});
        end
        if (en[1]) begin
            r2_mix <= n_mix;
        end
        if (en[2]) begin
            r3_yprod <= r2_mix * $signed({1'b0, i_cfg.gain});
        end
        if (en[3]) begin
            r4_sample <= y_clip[SAMPLE_BITS-1:0];
        end
    end

    assign o_ctl    = r_ctl[3];
    assign o_sample = r4_sample;

endmodule

### rtl/pws_chk.sv
// ----------------------------------------------------------------------------
// pws_chk
// Port-level checks on the polynomial waveshaper, bound to the top level.
// ----------------------------------------------------------------------------
module pws_chk #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic signed [SAMPLE_BITS-1:0] i_sample
);
    localparam logic signed [SAMPLE_BITS:0] CLIP =
        (SAMPLE_BITS+1)'((64'd99 * (64'd1 << (SAMPLE_BITS - 1))) / 64'd100);

    a_clip_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((SAMPLE_BITS+1)'(i_sample) <= CLIP) &&
                        ((SAMPLE_BITS+1)'(i_sample) >= -CLIP))
        else $error("sample beyond clip level");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid straight after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_sample))
        else $error("stalled result changed");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input held off with empty output stage");

endmodule

bind polynomial_waveshaper pws_chk #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_pws_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_item.valid),
    .i_out_ready (o_item.ready),
    .i_sample    (o_item.sample_out)
);

### tb/pws_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pws_checker
// Watches the register port and both item channels of the polynomial
// waveshaper. Keeps its own copy of the registers, works out the shaped
// sample for every accepted input item and compares each result item, field
// by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module pws_checker #(
    parameter int POLY_ORDER  = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [5:0]                    paddr,
    input  logic [63:0]                   pwdata,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_in_sample,
    input  logic                          i_in_eob,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_out_sample,
    input  logic                          i_out_eob,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_checked
);
    import pws_pkg::*;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          eob;
    } t_shaped;

    localparam longint CLIP_LEVEL = (longint'(99) << (SAMPLE_BITS - 1)) / 100;

    t_cfg    cfg;
    t_shaped shaped_q[$];
    int      fail_count = 0;
    int      checked = 0;

    function automatic longint sat_q16(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end else if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint coef_q16(input int k);
        logic signed [15:0] raw;
        if (k >= 8) begin
            raw = cfg.coef_top;
        end else if (k >= 4) begin
            raw = cfg.coef_hi[16*(k-4) +: 16];
        end else begin
            raw = cfg.coef_lo[16*k +: 16];
        end
        return longint'(raw) * 16;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] shape_sample(
        input logic signed [SAMPLE_BITS-1:0] x_in
    );
        longint x, u, acc, m, wet, dry, mixv, y;
        int     k;
        x   = longint'(x_in);
        u   = sat_q16((x * longint'(cfg.drive)) >>> (SAMPLE_BITS - 6));
        acc = coef_q16(POLY_ORDER);
        for (k = POLY_ORDER - 1; k >= 0; k--) begin
            acc = sat_q16((acc * u) >>> 16);
            acc = sat_q16(acc + coef_q16(k));
        end
        m    = (cfg.wet > 16'd32768) ? 64'sd32768 : longint'(cfg.wet);
        wet  = sat_q16((acc * m) >>> 15);
        dry  = sat_q16((x * (64'sd32768 - m)) >>> (SAMPLE_BITS - 2));
        mixv = sat_q16(wet + dry);
        y    = sat_q16((mixv * longint'(cfg.gain)) >>> 12);
        if (SAMPLE_BITS <= 17) begin
            y = y >>> (17 - SAMPLE_BITS);
        end else begin
            y = y <<< (SAMPLE_BITS - 17);
        end
        if (y > CLIP_LEVEL) begin
            y = CLIP_LEVEL;
        end else if (y < -CLIP_LEVEL) begin
            y = -CLIP_LEVEL;
        end
        return y[SAMPLE_BITS-1:0];
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: %s (got %0d, expected %0d)", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_shaped want;
        if (!i_rst_n) begin
            cfg.coef_lo  = '0;
            cfg.coef_hi  = '0;
            cfg.coef_top = '0;
            cfg.drive    = DRIVE_RST;
            cfg.wet      = WET_RST;
            cfg.gain     = GAIN_RST;
            shaped_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[5:3])
                    REG_COEF_LO:  cfg.coef_lo  = pwdata;
                    REG_COEF_HI:  cfg.coef_hi  = pwdata;
                    REG_COEF_TOP: cfg.coef_top = pwdata[15:0];
                    REG_DRIVE:    cfg.drive    = pwdata[15:0];
                    REG_WET:      cfg.wet      = pwdata[15:0];
                    REG_GAIN:     cfg.gain     = pwdata[15:0];
                    default:      ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                shaped_q.push_back('{sample: shape_sample(i_in_sample), eob: i_in_eob});
            end
            if (i_out_valid && i_out_ready) begin
                if (shaped_q.size() == 0) begin
                    report_mismatch("result item with nothing outstanding",
                                    longint'(i_out_sample), 0);
                end else begin
                    want = shaped_q.pop_front();
                    checked++;
                    if (i_out_sample !== want.sample) begin
                        report_mismatch("sample_out differs", longint'(i_out_sample),
                                        longint'(want.sample));
                    end
                    if (i_out_eob !== want.eob) begin
                        report_mismatch("end_of_buffer_out differs", longint'(i_out_eob),
                                        longint'(want.eob));
                    end
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= shaped_q.size();
        o_checked    <= checked;
    end

endmodule

### tb/tb_polynomial_waveshaper.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_polynomial_waveshaper
// Regression for the polynomial waveshaper: directed extremes and saturating
// settings, then random samples over a run of random register settings, with
// the sender and receiver idling at random for the first two thirds of the
// items. A checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_polynomial_waveshaper;
    import pws_pkg::*;

    localparam int POLY_ORDER    = 8;
    localparam int SAMPLE_BITS   = 16;
    localparam int DIRECTED      = 20;
    localparam int RANDOM_ITEMS  = 750;
    localparam int PHASE_COUNT   = 10;
    localparam int TOTAL_ITEMS   = DIRECTED + RANDOM_ITEMS;
    localparam int HOLD_CYCLES   = 2 * POLY_ORDER + 8;
    localparam int STALL_LIMIT   = 2000;

    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    typedef enum logic [1:0] {
        PACE_SENDER_LIGHT,
        PACE_SENDER_HEAVY,
        PACE_NONE
    } t_pace;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    t_pace       pace;
    int          items_sent = 0;
    int          settings_applied = 0;
    int          idle_run = 0;
    int          fail_count;
    int          pending;
    int          checked;

    pws_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
    pws_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_ch ();

    polynomial_waveshaper #(
        .POLY_ORDER  (POLY_ORDER),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_item  (in_ch),
        .o_item  (out_ch)
    );

    pws_checker #(
        .POLY_ORDER  (POLY_ORDER),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) shape_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_sample  (in_ch.sample_in),
        .i_in_eob     (in_ch.end_of_buffer),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_sample (out_ch.sample_out),
        .i_out_eob    (out_ch.end_of_buffer_out),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            case (pace)
                PACE_SENDER_LIGHT: out_ch.ready <= ($urandom_range(99) >= 48);
                PACE_SENDER_HEAVY: out_ch.ready <= ($urandom_range(99) >= 18);
                default:           out_ch.ready <= 1'b1;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (in_ch.valid && in_ch.ready)
                || (out_ch.valid && out_ch.ready)) begin
            idle_run <= 0;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    initial begin
        @(posedge i_clk);
        while (idle_run < STALL_LIMIT) @(posedge i_clk);
        $display("polynomial_waveshaper regression: fail");
        $finish;
    end

    task automatic write_register(input logic [2:0] index, input logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 3'b000};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // junk above bit 15 of the narrow registers must be dropped
    task automatic apply_setting(input t_cfg setting);
        write_register(REG_COEF_LO, setting.coef_lo);
        write_register(REG_COEF_HI, setting.coef_hi);
        write_register(REG_COEF_TOP, {$urandom, 16'($urandom), setting.coef_top});
        write_register(REG_DRIVE, {$urandom, 16'($urandom), setting.drive});
        write_register(REG_WET, {$urandom, 16'($urandom), setting.wet});
        write_register(REG_GAIN, {$urandom, 16'($urandom), setting.gain});
        write_register(REG_SPARE_A, {$urandom, $urandom});
        write_register(REG_SPARE_B, {$urandom, $urandom});
        settings_applied++;
    endtask

    task automatic push_sample(input logic [SAMPLE_BITS-1:0] s, input logic e);
        int idle_pct;
        idle_pct = (pace == PACE_SENDER_LIGHT) ? 18 : (pace == PACE_SENDER_HEAVY) ? 48 : 0;
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.sample_in     <= s;
        in_ch.end_of_buffer <= e;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
        if (items_sent < TOTAL_ITEMS / 3) begin
            pace <= PACE_SENDER_LIGHT;
        end else if (items_sent < 2 * TOTAL_ITEMS / 3) begin
            pace <= PACE_SENDER_HEAVY;
        end else begin
            pace <= PACE_NONE;
        end
    endtask

    // drain the pipeline, then hold idle for longer than its latency
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (HOLD_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        t_cfg                    setting;
        logic [15:0]             coefs [9];
        logic [SAMPLE_BITS-1:0]  s;
        int                      phase;
        int                      n;
        int                      k;

        i_rst_n             <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.sample_in     <= '0;
        in_ch.end_of_buffer <= 1'b0;
        pace                <= PACE_SENDER_LIGHT;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults straight after reset
        push_sample(16'h8000, 1'b1);
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'h0000, 1'b1);
        push_sample(16'hFFFF, 1'b0);

        // unity shaper: output follows the input up to the clip level
        wait_idle();
        apply_setting('{64'h0000_0000_1000_0000, 64'h0, 16'h0, 16'd2048, 16'd32768, 16'd4096});
        push_sample(16'h8000, 1'b0);
        push_sample(16'h7FFF, 1'b1);
        push_sample(16'h0001, 1'b0);
        push_sample(16'hFFFF, 1'b1);
        push_sample(16'h0000, 1'b0);
        push_sample(16'h4000, 1'b1);

        // positive saturation throughout, wet share above one
        wait_idle();
        apply_setting('{{4{16'h7FFF}}, {4{16'h7FFF}}, 16'h7FFF, 16'hFFFF, 16'hFFFF,
                        16'hFFFF});
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'h8000, 1'b1);
        push_sample(16'h0001, 1'b0);
        push_sample(16'hFFFF, 1'b1);
        push_sample(16'h0000, 1'b0);

        // negative coefficients, fully dry
        wait_idle();
        apply_setting('{{4{16'h8000}}, {4{16'h8000}}, 16'h8000, 16'hFFFF, 16'd0, 16'hFFFF});
        push_sample(16'h8000, 1'b1);
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'd100, 1'b1);

        // no drive: only c0 survives, wet share just above one
        wait_idle();
        apply_setting('{{$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom), 16'd0,
                        16'd32769, 16'd4096});
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'h8000, 1'b1);

        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            wait_idle();
            for (k = 0; k < 9; k++) begin
                case ($urandom_range(3))
                    0:       coefs[k] = $urandom_range(1) ? 16'h7FFF : 16'h8000;
                    1:       coefs[k] = 16'($urandom);
                    default: coefs[k] = 16'(int'($urandom_range(2048)) - 1024);
                endcase
            end
            setting.coef_lo  = {coefs[3], coefs[2], coefs[1], coefs[0]};
            setting.coef_hi  = {coefs[7], coefs[6], coefs[5], coefs[4]};
            setting.coef_top = coefs[8];
            case ($urandom_range(3))
                0:       setting.drive = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                1:       setting.drive = 16'($urandom);
                default: setting.drive = 16'($urandom_range(4096, 512));
            endcase
            case ($urandom_range(3))
                0:       setting.wet = $urandom_range(1) ? 16'd32768 : 16'd0;
                1:       setting.wet = 16'($urandom);
                default: setting.wet = 16'($urandom_range(32768));
            endcase
            case ($urandom_range(3))
                0:       setting.gain = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                1:       setting.gain = 16'($urandom);
                default: setting.gain = 16'($urandom_range(8192, 2048));
            endcase
            apply_setting(setting);
            for (n = 0; n < RANDOM_ITEMS / PHASE_COUNT; n++) begin
                case ($urandom_range(9))
                    0:       s = $urandom_range(1) ? 16'h7FFF : 16'h8000;
                    1:       s = 16'(int'($urandom_range(512)) - 256);
                    default: s = 16'($urandom);
                endcase
                push_sample(s, $urandom_range(7) == 0);
            end
        end

        wait_idle();
        $display("covered %0d items (%0d directed) over %0d register settings and three pacing regimes",
                 items_sent, DIRECTED, settings_applied);
        $display("%0d result items compared, %0d mismatches, %0d left waiting",
                 checked, fail_count, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("polynomial_waveshaper regression: pass");
        end else begin
            $display("polynomial_waveshaper regression: fail");
        end
        $finish;
    end

endmodule

### files.f
rtl/pws_pkg.sv
rtl/pws_in_if.sv
rtl/pws_out_if.sv
rtl/pws_cfg.sv
rtl/pws_front.sv
rtl/pws_horner_step.sv
rtl/pws_mix.sv
rtl/polynomial_waveshaper.sv
rtl/pws_chk.sv
tb/pws_checker.sv
tb/tb_polynomial_waveshaper.sv
